/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the parser top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and active-low reset
`define ASSERT_CLKD(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) else $error(msg);

// Shorthand for the block clock and reset
`define IPV6P_ASSERT(lbl, prop, msg) \
  `ASSERT_CLKD(lbl, clk, rst_n, prop, msg)

`endif

/* design/ipv6p_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Types and constants for the IPv6 text address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6p_pkg;

  localparam int unsigned SLOTS = 8;

  // ASCII codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Saturation points and limits
  localparam logic [16:0] ACC_SAT    = 17'h10000;
  localparam logic [8:0]  PFX_SAT    = 9'd256;
  localparam logic [7:0]  MAX_PREFIX = 8'd128;

  // Where in the line we are
  typedef enum logic [1:0] {
    POS_START = 2'd0,  // nothing seen yet
    POS_ZERO  = 2'd1,  // only a leading '0'
    POS_BODY  = 2'd2,  // past the first characters
    POS_HEX   = 2'd3   // "0x" form seen
  } ipv6p_pos_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_HEX     = 2'd2
  } ipv6p_status_t;

  // Eight 16-bit blocks, slot 0 is the most significant
  typedef logic [0:7][15:0] ipv6p_blocks_t;

  typedef struct packed {
    ipv6p_blocks_t left_w;       // left blocks at their final slots
    ipv6p_blocks_t right_w;      // right blocks, shifted in from the bottom
    logic [3:0]    left_count;
    logic [3:0]    right_count;
    logic          seen_dc;
    logic [16:0]   acc;
    logic [1:0]    colon_run;
    ipv6p_pos_t    pos;
    logic          in_prefix;
    logic [8:0]    pfx;
    logic          err;
  } ipv6p_state_t;

  localparam ipv6p_state_t STATE_RESET = '0;

endpackage

`default_nettype wire

/* design/ipv6p_step.sv */
// ----------------------------------------------------------------------------
// ipv6p_step
// Next-state logic: applies one character (and end of line) to the parser
// state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_step (
  input  ipv6p_pkg::ipv6p_state_t st,
  input  logic [7:0]              char_code,
  input  logic                    eol,
  output ipv6p_pkg::ipv6p_state_t st_nxt
);

  // Close the current block into the left slots or the right shift line
  function automatic ipv6p_pkg::ipv6p_state_t commit_blk(input ipv6p_pkg::ipv6p_state_t s);
    ipv6p_pkg::ipv6p_state_t r;
    logic [3:0]              n;
    r = s;
    n = s.left_count + s.right_count;
    if (n >= 4'(ipv6p_pkg::SLOTS) || s.acc[16]) begin
      r.err = 1'b1;
    end else begin
      if (s.seen_dc) begin
        r.right_w     = {s.right_w[1:7], s.acc[15:0]};
        r.right_count = s.right_count + 4'd1;
      end else begin
        r.left_w[n[2:0]] = s.acc[15:0];
        r.left_count     = s.left_count + 4'd1;
      end
      r.acc = '0;
    end
    return r;
  endfunction

  // End of the address part: last block and block count checks
  function automatic ipv6p_pkg::ipv6p_state_t end_addr(input ipv6p_pkg::ipv6p_state_t s);
    ipv6p_pkg::ipv6p_state_t r;
    logic [3:0]              n;
    r = s;
    if (r.pos == ipv6p_pkg::POS_START || r.colon_run == 2'd1) begin
      r.err = 1'b1;
    end else begin
      if (r.colon_run == 2'd0) r = commit_blk(r);
      if (!r.err) begin
        n = r.left_count + r.right_count;
        if (n == 4'd0 || (r.seen_dc && n >= 4'(ipv6p_pkg::SLOTS))) r.err = 1'b1;
      end
    end
    return r;
  endfunction

  logic        is_dec;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [12:0] pfx_mul;
  logic [20:0] acc_mul;

  // Character class decode
  always_comb begin
    is_dec = (char_code >= ipv6p_pkg::CH_ZERO) && (char_code <= ipv6p_pkg::CH_NINE);
    hex_ok = 1'b1;
    hex_d  = '0;
    priority if (is_dec) begin
      hex_d = 4'(char_code - ipv6p_pkg::CH_ZERO);
    end else if (char_code >= ipv6p_pkg::CH_LA && char_code <= ipv6p_pkg::CH_LF) begin
      hex_d = 4'(char_code - ipv6p_pkg::CH_LA + 8'd10);
    end else if (char_code >= ipv6p_pkg::CH_UA && char_code <= ipv6p_pkg::CH_UF) begin
      hex_d = 4'(char_code - ipv6p_pkg::CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    pfx_mul = {4'b0, st.pfx} * 13'd10 + {9'b0, hex_d};
    acc_mul = {st.acc, hex_d};
  end

  // State update for the character, then the end-of-line checks
  always_comb begin
    ipv6p_pkg::ipv6p_state_t s;
    s = st;
    if (s.pos != ipv6p_pkg::POS_HEX && !s.err) begin
      if (s.in_prefix) begin
        if (is_dec) begin
          s.pfx       = (pfx_mul > 13'd256) ? ipv6p_pkg::PFX_SAT : pfx_mul[8:0];
          s.colon_run = 2'd1;  // marks a digit seen
        end else begin
          s.err = 1'b1;
        end
      end else if (char_code == ipv6p_pkg::CH_SLASH) begin
        s           = end_addr(s);
        s.in_prefix = 1'b1;
        s.colon_run = 2'd0;
        s.pfx       = '0;
      end else if (s.pos == ipv6p_pkg::POS_ZERO && char_code == ipv6p_pkg::CH_X) begin
        s.pos = ipv6p_pkg::POS_HEX;
      end else begin
        if (char_code == ipv6p_pkg::CH_COLON) begin
          priority if (s.colon_run == 2'd0) begin
            s           = commit_blk(s);
            s.colon_run = 2'd1;
          end else if (s.colon_run == 2'd1) begin
            if (s.seen_dc) s.err = 1'b1;
            else           s.seen_dc = 1'b1;
            s.colon_run = 2'd2;
          end else begin
            s.err = 1'b1;  // triple colon
          end
        end else if (hex_ok) begin
          s.acc       = (acc_mul > 21'h10000) ? ipv6p_pkg::ACC_SAT : acc_mul[16:0];
          s.colon_run = 2'd0;
        end else begin
          s.err = 1'b1;
        end
        if (s.pos == ipv6p_pkg::POS_START) begin
          s.pos = (char_code == ipv6p_pkg::CH_ZERO) ? ipv6p_pkg::POS_ZERO
                                                    : ipv6p_pkg::POS_BODY;
        end else if (s.pos == ipv6p_pkg::POS_ZERO) begin
          s.pos = ipv6p_pkg::POS_BODY;
        end
      end
    end

    // Line end: close the address or check the prefix
    if (eol && s.pos != ipv6p_pkg::POS_HEX && !s.err) begin
      if (s.in_prefix) begin
        if (s.colon_run == 2'd0 || s.pfx > {1'b0, ipv6p_pkg::MAX_PREFIX}) s.err = 1'b1;
      end else begin
        s = end_addr(s);
      end
    end
    st_nxt = s;
  end

endmodule

`default_nettype wire

/* design/ipv6p_assemble.sv */
// ----------------------------------------------------------------------------
// ipv6p_assemble
// Builds the result word from the final line state: address, prefix, status.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_assemble (
  input  ipv6p_pkg::ipv6p_state_t st,
  output logic [63:0]             addr_high,
  output logic [63:0]             addr_low,
  output logic [7:0]              prefix_len,
  output logic [1:0]              status
);

  logic [127:0] addr;
  logic [3:0]   n;
  ipv6p_pkg::ipv6p_status_t stat;

  always_comb begin
    priority if (st.pos == ipv6p_pkg::POS_HEX) stat = ipv6p_pkg::ST_HEX;
    else if (st.err)                           stat = ipv6p_pkg::ST_INVALID;
    else                                       stat = ipv6p_pkg::ST_OK;

    // Left and right groups never overlap, unused slots are zero
    addr = st.left_w | st.right_w;
    n    = st.left_count + st.right_count;

    addr_high  = '0;
    addr_low   = '0;
    prefix_len = '0;
    if (stat == ipv6p_pkg::ST_OK) begin
      addr_high = addr[127:64];
      addr_low  = addr[63:0];
      priority if (st.in_prefix)          prefix_len = st.pfx[7:0];
      else if (st.right_count != 4'd0)    prefix_len = ipv6p_pkg::MAX_PREFIX;
      else                                prefix_len = {n, 4'b0};
    end
    status = stat;
  end

endmodule

`default_nettype wire

/* design/ipv6_text_address_parser.sv */
// out_valid is registered: a line's last character passes the input register, then sets the result register.
// Throughput: one character per cycle; the state update is a single
// registered pass between the input register and the result register.
// A line end stalls only while the result register holds an untaken result.
// Reset (rst_n low, synchronous) empties both registers and clears the line.
// ----------------------------------------------------------------------------
// ipv6_text_address_parser
// Top level: input register, parser state, result register and handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic [7:0]  out_prefix_len,
  output logic [1:0]  out_status
);

  logic                    in_valid_r;
  logic [7:0]              in_char_r;
  logic                    in_eol_r;
  ipv6p_pkg::ipv6p_state_t st_r;
  ipv6p_pkg::ipv6p_state_t st_nxt;
  logic                    out_valid_r;
  logic [63:0]             out_addr_high_r;
  logic [63:0]             out_addr_low_r;
  logic [7:0]              out_prefix_len_r;
  logic [1:0]              out_status_r;
  logic [63:0]             res_high;
  logic [63:0]             res_low;
  logic [7:0]              res_prefix;
  logic [1:0]              res_status;
  logic                    advance;
  logic                    process;
  logic                    emit;

  // Handshake: non-final characters never wait on the result side
  assign advance  = !out_valid_r || !out_stall;
  assign process  = in_valid_r && (!in_eol_r || advance);
  assign emit     = process && in_eol_r;
  assign in_stall = in_valid_r && !process;

  ipv6p_step u_step (
    .st        (st_r),
    .char_code (in_char_r),
    .eol       (in_eol_r),
    .st_nxt    (st_nxt)
  );

  ipv6p_assemble u_assemble (
    .st         (st_nxt),
    .addr_high  (res_high),
    .addr_low   (res_low),
    .prefix_len (res_prefix),
    .status     (res_status)
  );

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ipv6p_pkg::STATE_RESET;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (process) st_r <= in_eol_r ? ipv6p_pkg::STATE_RESET : st_nxt;
      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_char_r <= in_char_code;
      in_eol_r  <= in_end_of_line;
    end
    if (emit) begin
      out_addr_high_r  <= res_high;
      out_addr_low_r   <= res_low;
      out_prefix_len_r <= res_prefix;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_addr_high  = out_addr_high_r;
  assign out_addr_low   = out_addr_low_r;
  assign out_prefix_len = out_prefix_len_r;
  assign out_status     = out_status_r;

  // Checks
  `IPV6P_ASSERT(a_stall_only_eol,
                in_stall |-> (in_valid_r && in_eol_r && out_valid_r),
                "input stalled without a pending line end")
  `IPV6P_ASSERT(a_emit_shows, emit |=> out_valid, "line end did not produce a result")
  `IPV6P_ASSERT(a_err_zero,
                (out_valid && out_status != ipv6p_pkg::ST_OK) |->
                  (out_addr_high == 64'd0 && out_addr_low == 64'd0 && out_prefix_len == 8'd0),
                "failed result carries data")
  `IPV6P_ASSERT(a_line_clear,
                emit |=> (st_r.left_count == 4'd0 && st_r.right_count == 4'd0 &&
                          !st_r.in_prefix && !st_r.err),
                "state not cleared after line end")

endmodule

`default_nettype wire
